@@ hdl/aeis_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package aeis_pkg;

    // Default table depth per bank
    localparam int TABLE_DEPTH_DEF = 256;

    // Field widths
    localparam int IDX_W    = 8;
    localparam int VAL_W    = 16;
    localparam int DGOUT_W  = 13;
    localparam int CFG_IX_W = 3;
    localparam int CFG_DW   = 8;

    // Input kinds (tuser)
    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_STEP    = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IX_W-1:0] REG_USE_60HZ  = 3'd0;
    localparam logic [CFG_IX_W-1:0] REG_START_50  = 3'd1;
    localparam logic [CFG_IX_W-1:0] REG_START_60  = 3'd2;
    localparam logic [CFG_IX_W-1:0] REG_LAST_50   = 3'd3;
    localparam logic [CFG_IX_W-1:0] REG_LAST_60   = 3'd4;

    // Frame rate codes
    localparam logic [1:0] FR_30FPS = 2'd0;
    localparam logic [1:0] FR_25FPS = 2'd1;
    localparam logic [1:0] FR_20FPS = 2'd2;

    localparam logic [VAL_W-1:0] TIME_25FPS_LOW  = 16'h0354;
    localparam logic [VAL_W-1:0] TIME_25FPS_HIGH = 16'h0400;

    localparam logic [7:0] GAIN_CODE_MAX = 8'hF0;

    // One table entry as stored in memory
    typedef struct packed {
        logic [VAL_W-1:0] dig_gain;
        logic [VAL_W-1:0] ana_gain;
        logic [VAL_W-1:0] exp_time;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Step item travelling alongside the memory read
    typedef struct packed {
        logic [IDX_W-1:0] ev_index;
        logic             in_range;
    } rd_ctrl_t;

    // One result item
    typedef struct packed {
        logic [IDX_W-1:0]   ev_index;
        logic [VAL_W-1:0]   exposure_time;
        logic [1:0]         frame_rate_code;
        logic               frame_rate_changed;
        logic [7:0]         analog_gain_code;
        logic [DGOUT_W-1:0] digital_gain_out;
    } result_t;

    // Analog gain ladder, 8.8 fixed point, 1x to 16x
    function automatic logic [VAL_W-1:0] gain_ladder(input logic [6:0] k);
        logic [VAL_W-1:0] v;
        case (k)
            7'd0:  v = 16'd256;   7'd1:  v = 16'd271;   7'd2:  v = 16'd289;
            7'd3:  v = 16'd305;   7'd4:  v = 16'd320;   7'd5:  v = 16'd335;
            7'd6:  v = 16'd353;   7'd7:  v = 16'd369;   7'd8:  v = 16'd384;
            7'd9:  v = 16'd399;   7'd10: v = 16'd417;   7'd11: v = 16'd433;
            7'd12: v = 16'd448;   7'd13: v = 16'd463;   7'd14: v = 16'd481;
            7'd15: v = 16'd497;   7'd16: v = 16'd512;   7'd17: v = 16'd545;
            7'd18: v = 16'd576;   7'd19: v = 16'd609;   7'd20: v = 16'd640;
            7'd21: v = 16'd673;   7'd22: v = 16'd704;   7'd23: v = 16'd737;
            7'd24: v = 16'd768;   7'd25: v = 16'd801;   7'd26: v = 16'd832;
            7'd27: v = 16'd865;   7'd28: v = 16'd896;   7'd29: v = 16'd929;
            7'd30: v = 16'd960;   7'd31: v = 16'd993;   7'd32: v = 16'd1024;
            7'd33: v = 16'd1088;  7'd34: v = 16'd1152;  7'd35: v = 16'd1216;
            7'd36: v = 16'd1280;  7'd37: v = 16'd1344;  7'd38: v = 16'd1408;
            7'd39: v = 16'd1472;  7'd40: v = 16'd1536;  7'd41: v = 16'd1600;
            7'd42: v = 16'd1664;  7'd43: v = 16'd1728;  7'd44: v = 16'd1792;
            7'd45: v = 16'd1856;  7'd46: v = 16'd1920;  7'd47: v = 16'd1984;
            7'd48: v = 16'd2048;  7'd49: v = 16'd2176;  7'd50: v = 16'd2304;
            7'd51: v = 16'd2432;  7'd52: v = 16'd2560;  7'd53: v = 16'd2688;
            7'd54: v = 16'd2816;  7'd55: v = 16'd2944;  7'd56: v = 16'd3072;
            7'd57: v = 16'd3200;  7'd58: v = 16'd3328;  7'd59: v = 16'd3456;
            7'd60: v = 16'd3584;  7'd61: v = 16'd3712;  7'd62: v = 16'd3840;
            7'd63: v = 16'd3968;  7'd64: v = 16'd4096;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // Coarse/fine code: fine is the step within a group of 16,
    // coarse is 0, 1, 3, 7 for the four groups.
    function automatic logic [7:0] gain_code(input logic [VAL_W-1:0] gain);
        logic [5:0] step;
        logic [3:0] coarse;
        logic [7:0] code;
        step = '0;
        for (int k = 1; k < 64; k++) begin
            if (gain >= gain_ladder(7'(k))) begin
                step = 6'(k);
            end
        end
        case (step[5:4])
            2'd0:    coarse = 4'd0;
            2'd1:    coarse = 4'd1;
            2'd2:    coarse = 4'd3;
            default: coarse = 4'd7;
        endcase
        if (gain >= gain_ladder(7'd64)) begin
            code = GAIN_CODE_MAX;
        end else if (gain < gain_ladder(7'd0)) begin
            code = 8'd0;
        end else begin
            code = {coarse, step[3:0]};
        end
        return code;
    endfunction

endpackage

`default_nettype wire

@@ hdl/aeis_table_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Exposure table: one write port, one read port, registered read data.
module aeis_table_mem #(
    parameter int AW = 9,
    parameter int DW = 48
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [0:(2**AW)-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/aeis_result_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Decode the entry read for a step and hold the result item for the output.
module aeis_result_stage
    import aeis_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     rd_valid,
    input  wire rd_ctrl_t rd_ctrl,
    input  wire entry_t   rd_entry,
    output logic          advance,
    output logic          m_valid,
    input  wire logic     m_ready,
    output result_t       m_result
);

    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;
    logic [1:0] last_fr_reg;
    entry_t     ent;
    logic [1:0] fr_code;
    logic       take;

    assign advance = !out_valid_reg || m_ready;
    assign take    = rd_valid && advance;

    // Entries beyond the table read as zero
    assign ent = rd_ctrl.in_range ? rd_entry : '0;

    always_comb begin
        if (ent.exp_time > TIME_25FPS_HIGH) begin
            fr_code = FR_20FPS;
        end else if (ent.exp_time > TIME_25FPS_LOW) begin
            fr_code = FR_25FPS;
        end else begin
            fr_code = FR_30FPS;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (take) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            last_fr_reg   <= FR_30FPS;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                last_fr_reg <= fr_code;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_reg.ev_index           <= rd_ctrl.ev_index;
            out_reg.exposure_time      <= ent.exp_time;
            out_reg.frame_rate_code    <= fr_code;
            out_reg.frame_rate_changed <= (fr_code != last_fr_reg);
            out_reg.analog_gain_code   <= gain_code(ent.ana_gain);
            out_reg.digital_gain_out   <= ent.dig_gain[VAL_W-1:3];
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

endmodule

`default_nettype wire

@@ hdl/exposure_index_stepper.sv @@
`timescale 1ns / 1ps
`default_nettype none

// A step's result item passes the table read register and then the output register before it is valid on m_axis.
// Throughput: one item per cycle; a held m_axis result with a step behind it drops s_axis_tready.
// Load and restart items give no result item.
// Reset (aresetn low, synchronous) clears index, config and frame-rate history.
// The table memory is not cleared; entries read before they are loaded are undefined.
module exposure_index_stepper
    import aeis_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // Configuration write port
    input  wire logic                cfg_we,
    input  wire logic [CFG_IX_W-1:0] cfg_index,
    input  wire logic [CFG_DW-1:0]   cfg_wdata,
    // Input items
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // ev_delta[7:0], entry_bank[8], entry_index[16:9], entry_time[32:17],
    // entry_analog_gain[48:33], entry_digital_gain[64:49], zeros[71:65]
    input  wire logic [71:0]         s_axis_tdata,
    // action[1:0]
    input  wire logic [1:0]          s_axis_tuser,
    // Result items
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // ev_index[7:0], exposure_time[23:8], time_low_byte[31:24],
    // time_high_byte[39:32], frame_rate_code[41:40], frame_rate_changed[42],
    // analog_gain_code[50:43], digital_gain_out[63:51]
    output logic [63:0]              m_axis_tdata
);

    // Address bits of one bank, and a compare width that holds both
    // an index and the depth itself.
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = ((AW > IDX_W) ? AW : IDX_W) + 1;

    // Unpack the input item
    logic signed [IDX_W-1:0] in_delta;
    logic                    in_bank;
    logic [IDX_W-1:0]        in_index;
    entry_t                  in_entry;
    logic [1:0]              in_action;

    assign in_delta          = s_axis_tdata[7:0];
    assign in_bank           = s_axis_tdata[8];
    assign in_index          = s_axis_tdata[16:9];
    assign in_entry.exp_time = s_axis_tdata[32:17];
    assign in_entry.ana_gain = s_axis_tdata[48:33];
    assign in_entry.dig_gain = s_axis_tdata[64:49];
    assign in_action         = s_axis_tuser;

    // Configuration registers
    logic             use_60hz_reg;
    logic [IDX_W-1:0] start_50_reg, start_60_reg, last_50_reg, last_60_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_60hz_reg <= 1'b0;
            start_50_reg <= '0;
            start_60_reg <= '0;
            last_50_reg  <= '1;
            last_60_reg  <= '1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_USE_60HZ: use_60hz_reg <= cfg_wdata[0];
                REG_START_50: start_50_reg <= cfg_wdata[IDX_W-1:0];
                REG_START_60: start_60_reg <= cfg_wdata[IDX_W-1:0];
                REG_LAST_50:  last_50_reg  <= cfg_wdata[IDX_W-1:0];
                REG_LAST_60:  last_60_reg  <= cfg_wdata[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the read stage frees itself whenever the result stage can take it
    logic     rd_valid_reg, rd_valid_next;
    rd_ctrl_t rd_ctrl_reg;
    logic     advance;
    logic     accept, is_load, is_step, is_restart;

    assign s_axis_tready = !rd_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_load       = accept && (in_action == ACT_LOAD);
    assign is_step       = accept && (in_action == ACT_STEP);
    assign is_restart    = accept && (in_action == ACT_RESTART);

    // Index step: add the signed correction, clamp to the bank's last index, then to 0
    logic [IDX_W-1:0]        idx_reg, idx_next, step_idx, bank_last, bank_start;
    logic signed [IDX_W+1:0] sum;

    assign bank_last  = use_60hz_reg ? last_60_reg : last_50_reg;
    assign bank_start = use_60hz_reg ? start_60_reg : start_50_reg;
    assign sum        = $signed({2'b00, idx_reg}) + (IDX_W+2)'(in_delta);

    always_comb begin
        if (sum >= $signed({2'b00, bank_last})) begin
            step_idx = bank_last;
        end else if (sum < 0) begin
            step_idx = '0;
        end else begin
            step_idx = sum[IDX_W-1:0];
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (is_step) begin
            idx_next = step_idx;
        end else if (is_restart) begin
            idx_next = bank_start;
        end
    end

    always_comb begin
        rd_valid_next = rd_valid_reg;
        if (is_step) begin
            rd_valid_next = 1'b1;
        end else if (advance) begin
            rd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            idx_reg      <= idx_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // Hold the step's index and whether it lies inside the table
    always_ff @(posedge aclk) begin
        if (is_step) begin
            rd_ctrl_reg.ev_index <= step_idx;
            rd_ctrl_reg.in_range <= (CW'(step_idx) < CW'(TABLE_DEPTH));
        end
    end

    // Table memory, bank in the top address bit; drop loads beyond the table
    logic            wr_en;
    logic [AW:0]     wr_addr, rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    assign wr_en   = is_load && (CW'(in_index) < CW'(TABLE_DEPTH));
    assign wr_addr = {in_bank, AW'(in_index)};
    assign rd_addr = {use_60hz_reg, AW'(step_idx)};

    aeis_table_mem #(
        .AW (AW + 1),
        .DW (ENTRY_W)
    ) u_table_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_entry),
        .rd_en   (is_step),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Decode and output register
    result_t res;

    aeis_result_stage u_result_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_valid (rd_valid_reg),
        .rd_ctrl  (rd_ctrl_reg),
        .rd_entry (entry_t'(rd_data)),
        .advance  (advance),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_result (res)
    );

    assign m_axis_tdata = {res.digital_gain_out,
                           res.analog_gain_code,
                           res.frame_rate_changed,
                           res.frame_rate_code,
                           res.exposure_time[15:8],
                           res.exposure_time[7:0],
                           res.exposure_time,
                           res.ev_index};

endmodule

`default_nettype wire
